>>> hdl/bpl_pkg.sv
// ----------------------------------------------------------------------------
// bpl_pkg: shared types for the bounded positional list
// Request modes, result status codes and the command handed to each cell.
// ----------------------------------------------------------------------------
`default_nettype none

package bpl_pkg;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_POP_FRONT  = 3'd1,
    MODE_PUSH_BACK  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_INSERT     = 3'd4,
    MODE_DELETE     = 3'd5,
    MODE_READ       = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_NOPOS  = 3'd2,
    ST_FULL   = 3'd3,
    ST_APPEND = 3'd4
  } status_e;

  // Per-cycle command broadcast along the row of cells
  typedef struct packed {
    logic ins;  // open a slot at the target index
    logic del;  // close the slot at the target index
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> hdl/bpl_if.sv
// ----------------------------------------------------------------------------
// bpl_if: request and response channels of the bounded positional list
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpl_req_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  mode;
  logic        [15:0] position;
  logic signed [31:0] item_value;

  modport source (output valid, mode, position, item_value, input ready);
  modport sink   (input valid, mode, position, item_value, output ready);
endinterface

interface bpl_rsp_if #(
  parameter int CNT_W = 5
);
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic signed [31:0] out_value;
  logic [CNT_W-1:0]   count;

  modport source (output valid, status, out_value, count, input ready);
  modport sink   (input valid, status, out_value, count, output ready);
endinterface

`default_nettype wire

>>> hdl/bounded_positional_list.sv
// ----------------------------------------------------------------------------
// bounded_positional_list: ordered store of up to DEPTH signed words
// Requests push/pop at either end, insert, delete or read at a 1-based
// position; each returns a status, a value and the new count.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per transfer (mode, position, item_value);
//   rsp_o returns exactly one result per request (status, out_value, count).
//   The words sit in a row of DEPTH cells; on a transfer every cell holds,
//   loads, or takes the word of a neighbour in the same cycle, and the
//   result of the request is registered.
//   The result appears in the cycle after the request transfer.
//   One request per cycle is taken while rsp_o.ready is high or no result
//   is pending; the whole cell row updates together on the transfer.
//   When the receiver stalls, the result is held and req_i.ready follows
//   rsp_o.ready, so at most one result is pending.
//   Reset empties the list (count 0), holds req_i.ready low and drops any
//   pending result; the cell contents are not cleared and are only seen
//   once written.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_positional_list
  import bpl_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bpl_req_if.sink    req_i,
  bpl_rsp_if.source  rsp_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 17;

  logic [CNT_W-1:0]   used_q, used_d;
  logic               valid_q;
  status_e            status_q, status_d;
  logic signed [31:0] value_q;
  logic [CNT_W-1:0]   count_q;

  cell_cmd_t          cmd, cmd_gated;
  logic [IDX_W-1:0]   at;
  logic [IDX_W-1:0]   rd_idx;
  logic               take;
  logic               accept;
  logic               full, empty;
  logic [POS_W-1:0]   pos_w, used_w;
  logic               pos_rd_ok, pos_ins_ok;
  mode_e              mode;
  logic signed [31:0] words [DEPTH];
  logic signed [31:0] rd_word;

  // hold off requests while in reset
  assign req_i.ready = rst_ni && (!valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign mode       = mode_e'(req_i.mode);
  assign full       = (used_q == CNT_W'(DEPTH));
  assign empty      = (used_q == '0);
  assign pos_w      = POS_W'(req_i.position);
  assign used_w     = POS_W'(used_q);
  assign pos_rd_ok  = (req_i.position != '0) && (pos_w <= used_w);
  assign pos_ins_ok = (req_i.position != '0) && (pos_w <= used_w + POS_W'(1));

  always_comb begin
    cmd      = '0;
    at       = '0;
    rd_idx   = '0;
    take     = 1'b0;
    status_d = ST_OK;
    used_d   = used_q;
    case (mode)
      MODE_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          used_d  = used_q + CNT_W'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          cmd.del = 1'b1;
          take    = 1'b1;
          used_d  = used_q - CNT_W'(1);
        end
      end
      MODE_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          at      = IDX_W'(used_q);
          used_d  = used_q + CNT_W'(1);
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          // the tail word just drops out of range, no shift needed
          rd_idx = IDX_W'(used_q - CNT_W'(1));
          take   = 1'b1;
          used_d = used_q - CNT_W'(1);
        end
      end
      MODE_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          used_d  = used_q + CNT_W'(1);
          if (pos_ins_ok) begin
            at = IDX_W'(req_i.position - 16'd1);
          end else begin
            at       = IDX_W'(used_q);
            status_d = ST_APPEND;
          end
        end
      end
      MODE_DELETE: begin
        if (pos_rd_ok) begin
          cmd.del = 1'b1;
          at      = IDX_W'(req_i.position - 16'd1);
          rd_idx  = IDX_W'(req_i.position - 16'd1);
          take    = 1'b1;
          used_d  = used_q - CNT_W'(1);
        end else begin
          status_d = ST_NOPOS;
        end
      end
      MODE_READ: begin
        if (pos_rd_ok) begin
          rd_idx = IDX_W'(req_i.position - 16'd1);
          take   = 1'b1;
        end else begin
          status_d = ST_NOPOS;
        end
      end
      default: begin
      end
    endcase
  end

  // cells move only on a request transfer
  assign cmd_gated = accept ? cmd : '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] prev_word;
    logic signed [31:0] next_word;

    if (i == 0) begin : g_first
      assign prev_word = words[i];
    end else begin : g_mid_prev
      assign prev_word = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_word = words[i];
    end else begin : g_mid_next
      assign next_word = words[i+1];
    end

    bpl_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd_gated),
      .at_i   (at),
      .word_i (req_i.item_value),
      .prev_i (prev_word),
      .next_i (next_word),
      .word_o (words[i])
    );
  end

  assign rd_word = words[rd_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      valid_q  <= 1'b0;
      status_q <= ST_OK;
      value_q  <= '0;
      count_q  <= '0;
    end else begin
      if (accept) begin
        used_q   <= used_d;
        valid_q  <= 1'b1;
        status_q <= status_d;
        value_q  <= take ? rd_word : 32'sd0;
        count_q  <= used_d;
      end else if (rsp_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid     = valid_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.out_value = value_q;
  assign rsp_o.count     = count_q;

endmodule

`default_nettype wire

>>> hdl/bpl_cell.sv
// ----------------------------------------------------------------------------
// bpl_cell: one storage cell of the list
// Holds one word; loads the new word, takes its front neighbour's word on an
// insert behind the target, or its back neighbour's word on a delete.
// ----------------------------------------------------------------------------
`default_nettype none

module bpl_cell
  import bpl_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX   = 0
) (
  input  wire logic                       clk_i,
  input  wire cell_cmd_t                  cmd_i,
  input  wire logic [$clog2(DEPTH)-1:0]   at_i,
  input  wire logic signed [31:0]         word_i,
  input  wire logic signed [31:0]         prev_i,
  input  wire logic signed [31:0]         next_i,
  output logic signed [31:0]              word_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic signed [31:0] word_q;
  logic signed [31:0] word_d;

  always_comb begin
    word_d = word_q;
    if (cmd_i.ins) begin
      if (MY_IDX == at_i) begin
        word_d = word_i;
      end else if (MY_IDX > at_i) begin
        word_d = prev_i;
      end
    end else if (cmd_i.del) begin
      // close the gap: every cell from the target onwards moves one forward
      if (MY_IDX >= at_i) begin
        word_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

`default_nettype wire
